### hw/rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg: shared definitions of the EMA crossover detector
// Widths, register indexes, order codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned SAMPLES_PER_BAR_DEF = 5;
  localparam int unsigned FILL_W   = 3;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SYM_W    = 16;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned EMA_W    = 48;
  localparam int unsigned FRAC_EXT = 16;
  localparam int unsigned DVD_W    = SUM_W + FRAC_EXT;
  localparam int unsigned DVS_W    = PERIOD_W + 1;
  localparam int unsigned CNT_W    = $clog2(DVD_W + 1);
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 144;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned IDX_W      = 8;

  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 8'd9;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 8'd21;
  localparam logic [PERIOD_W-1:0] BARS_MAX         = 8'd255;

  localparam logic [IDX_W-1:0] REG_SHORT_PERIOD = 8'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PERIOD  = 8'd1;

  typedef enum logic [1:0] {
    ORDER_UNDEF = 2'd0,
    ORDER_ABOVE = 2'd1,
    ORDER_BELOW = 2'd2
  } order_t;

  typedef struct packed {
    logic capture;
    logic sel_long;
    logic div_start;
    logic apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bar_done;
    logic need_div;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/ecd_divider.sv
// ----------------------------------------------------------------------------
// ecd_divider: restoring divider, one quotient bit per cycle
// Latches the operands on start and pulses done with the quotient held.
// ----------------------------------------------------------------------------
module ecd_divider
  import ecd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restore when the trial subtraction goes negative
      if (diff[DVS_W]) begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### hw/rtl/ecd_datapath.sv
// ----------------------------------------------------------------------------
// ecd_datapath: bar, running sum, EMA state and result register
// Executes controller commands; shares one divider between both averages.
// ----------------------------------------------------------------------------
module ecd_datapath
  import ecd_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_BAR = SAMPLES_PER_BAR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  logic [PERIOD_W-1:0] short_period_r, short_period_nxt;
  logic [PERIOD_W-1:0] long_period_r, long_period_nxt;
  logic [FILL_W-1:0]   bar_fill_r, bar_fill_nxt;
  logic [TIME_W-1:0]   bar_start_r, bar_start_nxt;
  logic [PERIOD_W-1:0] bars_seen_r, bars_seen_nxt;
  logic [SUM_W-1:0]    close_sum_r, close_sum_nxt;
  logic [EMA_W-1:0]    short_ema_r, short_ema_nxt;
  logic [EMA_W-1:0]    long_ema_r, long_ema_nxt;
  logic                short_rdy_r, short_rdy_nxt;
  logic                long_rdy_r, long_rdy_nxt;
  order_t              last_order_r, last_order_nxt;
  logic [PRICE_W-1:0]  close_r, close_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [PRICE_W-1:0]  in_close;
  logic [TIME_W-1:0]   in_time;
  logic [SYM_W-1:0]    in_sym;
  logic [FILL_W-1:0]   fill_inc;
  logic [PERIOD_W-1:0] period_sel;
  logic [PERIOD_W-1:0] p_eff;
  logic [EMA_W-1:0]    ema_sel;
  logic                rdy_sel;
  logic                seed_sel;
  logic [EMA_W-1:0]    close24;
  logic                ge;
  logic [EMA_W-1:0]    diff;
  logic [DVD_W-1:0]    dividend;
  logic [DVS_W-1:0]    divisor;
  logic [DVD_W-1:0]    quotient;
  logic                div_done;
  logic [EMA_W-1:0]    ema_new;
  order_t              cur_order;
  logic                sig;
  logic [PRICE_W-1:0]  sig_price;
  logic [TIME_W-1:0]   sig_time;
  logic [SYM_W-1:0]    sig_sym;

  assign in_close = in_tdata[PRICE_W-1:0];
  assign in_time  = in_tdata[PRICE_W+TIME_W-1:PRICE_W];
  assign in_sym   = in_tdata[PRICE_W+TIME_W+SYM_W-1:PRICE_W+TIME_W];
  assign fill_inc = bar_fill_r + FILL_W'(1);

  // operand selection for the average being worked on
  always_comb begin
    period_sel = cmd.sel_long ? long_period_r : short_period_r;
    p_eff      = (period_sel == '0) ? PERIOD_W'(1) : period_sel;
    ema_sel    = cmd.sel_long ? long_ema_r : short_ema_r;
    rdy_sel    = cmd.sel_long ? long_rdy_r : short_rdy_r;
    seed_sel   = !rdy_sel && (bars_seen_r >= p_eff);
    close24    = {close_r, FRAC_EXT'(0)};
    ge         = close24 >= ema_sel;
    diff       = ge ? (close24 - ema_sel) : (ema_sel - close24);
    if (seed_sel) begin
      dividend = {close_sum_r, FRAC_EXT'(0)};
      divisor  = {1'b0, bars_seen_r};
    end else begin
      dividend = DVD_W'({diff, 1'b0});
      divisor  = {1'b0, p_eff} + DVS_W'(1);
    end
    if (seed_sel) begin
      ema_new = quotient[EMA_W-1:0];
    end else if (ge) begin
      ema_new = ema_sel + quotient[EMA_W-1:0];
    end else begin
      ema_new = ema_sel - quotient[EMA_W-1:0];
    end
  end

  ecd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    cur_order = (short_ema_r > long_ema_r) ? ORDER_ABOVE : ORDER_BELOW;
    sig       = done_r && short_rdy_r && long_rdy_r &&
                (last_order_r != ORDER_UNDEF) && (cur_order != last_order_r);
    sig_price = sig ? close_r : '0;
    sig_time  = sig ? bar_start_r : '0;
    sig_sym   = sig ? sym_r : '0;
  end

  always_comb begin
    short_period_nxt = short_period_r;
    long_period_nxt  = long_period_r;
    bar_fill_nxt     = bar_fill_r;
    bar_start_nxt    = bar_start_r;
    bars_seen_nxt    = bars_seen_r;
    close_sum_nxt    = close_sum_r;
    short_ema_nxt    = short_ema_r;
    long_ema_nxt     = long_ema_r;
    short_rdy_nxt    = short_rdy_r;
    long_rdy_nxt     = long_rdy_r;
    last_order_nxt   = last_order_r;
    close_nxt        = close_r;
    sym_nxt          = sym_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    out_user_nxt     = out_user_r;

    if (cfg_valid) begin
      if (cfg_index == REG_SHORT_PERIOD) short_period_nxt = cfg_data;
      if (cfg_index == REG_LONG_PERIOD)  long_period_nxt  = cfg_data;
    end

    if (cmd.capture) begin
      close_nxt = in_close;
      sym_nxt   = in_sym;
      if (bar_fill_r == '0) bar_start_nxt = in_time;
      if (fill_inc >= FILL_W'(SAMPLES_PER_BAR)) begin
        done_nxt     = 1'b1;
        bar_fill_nxt = '0;
        if (bars_seen_r < BARS_MAX) begin
          close_sum_nxt = close_sum_r + SUM_W'(in_close);
          bars_seen_nxt = bars_seen_r + PERIOD_W'(1);
        end
      end else begin
        done_nxt     = 1'b0;
        bar_fill_nxt = fill_inc;
      end
    end

    if (cmd.apply) begin
      if (cmd.sel_long) begin
        long_ema_nxt = ema_new;
        long_rdy_nxt = 1'b1;
      end else begin
        short_ema_nxt = ema_new;
        short_rdy_nxt = 1'b1;
      end
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (cmd.load_out) begin
      if (done_r && short_rdy_r && long_rdy_r) last_order_nxt = cur_order;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {long_ema_r[EMA_W-1:FRAC_EXT], short_ema_r[EMA_W-1:FRAC_EXT],
                       sig_sym, sig_time, sig_price};
      out_user_nxt  = {sig && (cur_order == ORDER_ABOVE), sig, done_r};
    end
  end

  always_ff @(posedge clk) begin
    bar_start_r <= bar_start_nxt;
    close_r     <= close_nxt;
    sym_r       <= sym_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    if (!rst_n) begin
      short_period_r <= SHORT_PERIOD_RST;
      long_period_r  <= LONG_PERIOD_RST;
      bar_fill_r     <= '0;
      bars_seen_r    <= '0;
      close_sum_r    <= '0;
      short_ema_r    <= '0;
      long_ema_r     <= '0;
      short_rdy_r    <= 1'b0;
      long_rdy_r     <= 1'b0;
      last_order_r   <= ORDER_UNDEF;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      short_period_r <= short_period_nxt;
      long_period_r  <= long_period_nxt;
      bar_fill_r     <= bar_fill_nxt;
      bars_seen_r    <= bars_seen_nxt;
      close_sum_r    <= close_sum_nxt;
      short_ema_r    <= short_ema_nxt;
      long_ema_r     <= long_ema_nxt;
      short_rdy_r    <= short_rdy_nxt;
      long_rdy_r     <= long_rdy_nxt;
      last_order_r   <= last_order_nxt;
      done_r         <= done_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign sts.bar_done = done_r;
  assign sts.need_div = seed_sel || rdy_sel;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### hw/rtl/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl: sequencing state machine
// Captures a sample, runs the short then the long average, loads the result.
// ----------------------------------------------------------------------------
module ecd_ctrl
  import ecd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_SHORT_CHK  = 6'b000010,
    ST_SHORT_WAIT = 6'b000100,
    ST_LONG_CHK   = 6'b001000,
    ST_LONG_WAIT  = 6'b010000,
    ST_FINISH     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SHORT_CHK;
        end
      end
      ST_SHORT_CHK: begin
        if (sts.bar_done && sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_SHORT_WAIT;
        end else begin
          state_nxt = ST_LONG_CHK;
        end
      end
      ST_SHORT_WAIT: begin
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = ST_LONG_CHK;
        end
      end
      ST_LONG_CHK: begin
        cmd.sel_long = 1'b1;
        if (sts.bar_done && sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_LONG_WAIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LONG_WAIT: begin
        cmd.sel_long = 1'b1;
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### hw/rtl/ema_crossover_detector_top.sv
// ----------------------------------------------------------------------------
// ema_crossover_detector_top: bar builder and EMA crossover signal generator
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one sample; every SAMPLES_PER_BAR samples make a
// bar whose close drives a short and a long EMA, and each sample gives exactly
// one result transaction. A sample that does not close a bar passes through the
// short check, long check and finish states, and its result is loaded in finish. A
// bar-closing sample also waits on one shared restoring divider producing one
// bit per cycle, run for each average that needs a seed or an update, short
// then long. A held result delays the next load until out_tready. The next
// sample is accepted once the result has been loaded, even while it still
// waits on out_tready. Configuration writes are taken in any cycle (cfg_ready
// is always high).
module ema_crossover_detector_top
  import ecd_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_BAR = SAMPLES_PER_BAR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // close_price[31:0], sample_time[63:32], symbol_tag[79:64]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // signal_price[31:0], signal_time[63:32], signal_symbol[79:64],
  // short_average[111:80], long_average[143:112]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // bar_done[0], signal_valid[1], signal_side[2]
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ecd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ecd_datapath #(
    .SAMPLES_PER_BAR (SAMPLES_PER_BAR)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while previous sample in progress");

  a_div_only_on_bar: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.bar_done)
    else $error("divider started without a completed bar");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten while held");
`endif

endmodule

### sim/tb_ema_crossover_detector_top.sv
// ----------------------------------------------------------------------------
// tb_ema_crossover_detector_top: stream test of the EMA crossover detector
// Drives samples with random gaps, predicts every result transaction from a
// bit-exact model of bars, EMA seeding and crossover, and checks each field.
// ----------------------------------------------------------------------------
module tb_ema_crossover_detector_top;
  import ecd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] long_avg;
    logic [31:0] short_avg;
    logic [15:0] sym;
    logic [31:0] stime;
    logic [31:0] sprice;
    logic        side;
    logic        valid;
    logic        done;
  } signal_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [PERIOD_W-1:0]   cfg_data = '0;

  ema_crossover_detector_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  short_len, long_len;
  logic [2:0]  fill;
  logic [31:0] bar_t0;
  logic [7:0]  nbars;
  logic [39:0] csum;
  logic [47:0] ema_s, ema_l;
  logic        rdy_s, rdy_l;
  order_t      order;

  signal_t     expected_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          signals_seen = 0;
  int          cycles = 0;
  bit          quiet_in = 0, quiet_out = 0;

  function automatic logic [47:0] ema_next(logic [47:0] e, logic [47:0] c, logic [7:0] p);
    logic [63:0] d;
    d = {8'd0, p} + 1;
    if (c >= e) return e + 48'(((64'(c) - e) * 2) / d);
    return e - 48'(((64'(e) - c) * 2) / d);
  endfunction

  task automatic predict_signal(logic [31:0] close, logic [31:0] stamp, logic [15:0] sym);
    signal_t     r;
    logic [47:0] c24;
    logic [7:0]  ps, pl;
    order_t      cur;
    r = '0;
    if (fill == 0) bar_t0 = stamp;
    fill = fill + 1;
    if (fill >= 5) begin
      r.done = 1;
      fill = 0;
      c24 = {close, 16'd0};
      ps = (short_len == 0) ? 8'd1 : short_len;
      pl = (long_len == 0) ? 8'd1 : long_len;
      if (nbars < 255) begin
        csum = csum + close;
        nbars = nbars + 1;
      end
      if (!rdy_s && nbars >= ps) begin
        ema_s = 48'(({8'd0, csum, 16'd0}) / nbars);
        rdy_s = 1;
      end else if (rdy_s) ema_s = ema_next(ema_s, c24, ps);
      if (!rdy_l && nbars >= pl) begin
        ema_l = 48'(({8'd0, csum, 16'd0}) / nbars);
        rdy_l = 1;
      end else if (rdy_l) ema_l = ema_next(ema_l, c24, pl);
      if (rdy_s && rdy_l) begin
        cur = (ema_s > ema_l) ? ORDER_ABOVE : ORDER_BELOW;
        if (order == ORDER_UNDEF) order = cur;
        else if (cur != order) begin
          r.valid = 1;
          r.side = (cur == ORDER_ABOVE);
          r.sprice = close;
          r.stime = bar_t0;
          r.sym = sym;
          order = cur;
        end
      end
    end
    r.short_avg = ema_s[47:16];
    r.long_avg = ema_l[47:16];
    expected_q.insert(expected_q.size(), r);
  endtask

  // tvalid stays high after a transaction; the next gap or drain drops it
  task automatic send_sample(logic [31:0] close, logic [31:0] stamp, logic [15:0] sym);
    while (!quiet_in && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sym, stamp, close};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_signal(close, stamp, sym);
  endtask

  // drop tvalid and wait until every expected result has been taken, then idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_SHORT_PERIOD) short_len = val;
    else long_len = val;
  endtask

  always @(posedge clk) begin
    signal_t got, want;
    cycles <= cycles + 1;
    if (rst_n) out_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 10);
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[143:80], out_tdata[79:0], out_tuser};
      results_seen++;
      if (got.valid) signals_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp done%b sig%b side%b p%h t%h s%h sa%h la%h | got %b%b%b %h %h %h %h %h",
                     want.done, want.valid, want.side, want.sprice, want.stime, want.sym,
                     want.short_avg, want.long_avg, got.done, got.valid, got.side,
                     got.sprice, got.stime, got.sym, got.short_avg, got.long_avg);
        end
      end
    end
    if (cycles > 2000000) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // trending price: a rising then falling ramp gives crossovers both ways
  task automatic run_bars(int nsamp, int wave, int noise);
    int phase;
    logic [31:0] base;
    for (int i = 0; i < nsamp; i++) begin
      phase = (i / 5) % (2 * wave);
      base = 32'h0001_0000 + ((phase < wave) ? phase : 2 * wave - phase) * 32'h400;
      send_sample(base + $urandom_range(noise), $urandom, 16'($urandom));
    end
  endtask

  task automatic test_defaults();
    run_bars(200, 12, 256);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(REG_SHORT_PERIOD, 8'd0);
    write_reg(REG_LONG_PERIOD, 8'd1);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_sample(32'h0, 32'h0, 16'h0);
    for (int i = 0; i < 10; i++) send_sample(32'hFFFF_FFFF, 32'h1234_5678, 16'hA5A5);
    drain();
  endtask

  task automatic test_periods();
    write_reg(REG_SHORT_PERIOD, 8'd2);
    write_reg(REG_LONG_PERIOD, 8'd5);
    quiet_in = 1;
    quiet_out = 1;
    run_bars(150, 6, 2048);
    quiet_in = 0;
    quiet_out = 0;
    drain();
    write_reg(REG_SHORT_PERIOD, 8'd7);
    write_reg(REG_LONG_PERIOD, 8'd3);
    run_bars(150, 8, 4096);
    drain();
  endtask

  // long run of random samples with periods near the 255 maximum
  task automatic test_saturation();
    write_reg(REG_LONG_PERIOD, 8'd255);
    write_reg(REG_SHORT_PERIOD, 8'd254);
    for (int i = 0; i < 350; i++) send_sample($urandom, $urandom, 16'($urandom));
    drain();
    write_reg(REG_SHORT_PERIOD, 8'd4);
    write_reg(REG_LONG_PERIOD, 8'd12);
    run_bars(100, 5, 1024);
    drain();
  endtask

  initial begin
    short_len = SHORT_PERIOD_RST;
    long_len = LONG_PERIOD_RST;
    fill = 0; bar_t0 = 0; nbars = 0; csum = 0;
    ema_s = 0; ema_l = 0; rdy_s = 0; rdy_l = 0; order = ORDER_UNDEF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_periods();
    test_saturation();
    $display("covered %0d results, %0d crossover signals, periods 0..255", results_seen,
             signals_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
